// File: rtl/elrc_pkg.sv
package elrc_pkg;

    localparam int OFB_DEFAULT = 16;
    localparam int OPEN_W      = 17;
    localparam int POS_W       = 24;
    localparam int STEP_W      = 20;
    localparam int LEVEL_W     = 17;
    localparam int DIV_W       = 20;
    localparam int MUL_A_W     = 21;
    localparam int MUL_B_W     = 26;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int PC_W        = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] MODE_VELOCITY = 2'd0;
    localparam logic [1:0] MODE_POSITION = 2'd1;
    localparam logic [1:0] MODE_RAW      = 2'd2;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_RAW      = 2'd1;
    localparam logic [1:0] KIND_POSITION = 2'd2;
    localparam logic [1:0] KIND_VELOCITY = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_CLOSED_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_OPEN_VALUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LID_OPEN_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LID_CLOSED_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT   = 3'd7;

    localparam logic [PC_W-1:0] STEP_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] STEP_DIV     = 4'd1;
    localparam logic [PC_W-1:0] STEP_MUL_LEV = 4'd2;
    localparam logic [PC_W-1:0] STEP_CLAMP   = 4'd3;
    localparam logic [PC_W-1:0] STEP_MUL_REF = 4'd4;
    localparam logic [PC_W-1:0] STEP_REF     = 4'd5;
    localparam logic [PC_W-1:0] STEP_MUL_RAW = 4'd6;
    localparam logic [PC_W-1:0] STEP_RAW     = 4'd7;
    localparam logic [PC_W-1:0] STEP_MUL_VEL = 4'd8;
    localparam logic [PC_W-1:0] STEP_VEL     = 4'd9;
    localparam logic [PC_W-1:0] STEP_EMIT    = 4'd10;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LEV,
        MUL_REF,
        MUL_RAW,
        MUL_VEL
    } mul_sel_t;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_LOAD,
        ALU_DIV,
        ALU_CLAMP,
        ALU_REF,
        ALU_RAW,
        ALU_VEL,
        ALU_EMIT
    } alu_op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_DIV_LAST,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        mul_sel_t        mul_sel;
        alu_op_t         alu_op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctl_word_t;

    typedef struct packed {
        logic [1:0]        control_mode;
        logic [STEP_W-1:0] level_step;
        logic [7:0]        raw_closed_value;
        logic [7:0]        raw_open_value;
        logic [POS_W-1:0]  lid_open_limit;
        logic [POS_W-1:0]  lid_closed_limit;
        logic [15:0]       velocity_gain;
        logic [22:0]       velocity_limit;
    } cfg_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [7:0]         raw;
        logic [POS_W-1:0]   pos_ref;
        logic [POS_W-1:0]   vel;
        logic               encoder_ok;
    } dp_result_t;

    function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        unique case (pc)
            STEP_IDLE:    w = '{MUL_NONE, ALU_LOAD,  COND_IN_BEAT,  STEP_DIV};
            STEP_DIV:     w = '{MUL_NONE, ALU_DIV,   COND_DIV_LAST, STEP_MUL_LEV};
            STEP_MUL_LEV: w = '{MUL_LEV,  ALU_NONE,  COND_ALWAYS,   STEP_CLAMP};
            STEP_CLAMP:   w = '{MUL_NONE, ALU_CLAMP, COND_ALWAYS,   STEP_MUL_REF};
            STEP_MUL_REF: w = '{MUL_REF,  ALU_NONE,  COND_ALWAYS,   STEP_REF};
            STEP_REF:     w = '{MUL_NONE, ALU_REF,   COND_ALWAYS,   STEP_MUL_RAW};
            STEP_MUL_RAW: w = '{MUL_RAW,  ALU_NONE,  COND_ALWAYS,   STEP_RAW};
            STEP_RAW:     w = '{MUL_NONE, ALU_RAW,   COND_ALWAYS,   STEP_MUL_VEL};
            STEP_MUL_VEL: w = '{MUL_VEL,  ALU_NONE,  COND_ALWAYS,   STEP_VEL};
            STEP_VEL:     w = '{MUL_NONE, ALU_VEL,   COND_ALWAYS,   STEP_EMIT};
            STEP_EMIT:    w = '{MUL_NONE, ALU_EMIT,  COND_OUT_FREE, STEP_IDLE};
            default:      w = '{MUL_NONE, ALU_NONE,  COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/elrc_datapath.sv
module elrc_datapath
    import elrc_pkg::*;
#(
    parameter int OPENNESS_FRACTION_BITS = OFB_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctl_word_t           ctl,
    input  logic                in_beat,
    input  logic [OPEN_W-1:0]   left_openness,
    input  logic [OPEN_W-1:0]   right_openness,
    input  logic [POS_W-1:0]    measured_position,
    input  logic                encoder_ok,
    input  cfg_t                cfg,
    output dp_status_t          status,
    output dp_result_t          result
);

    localparam int CMP_W = (OPENNESS_FRACTION_BITS + 1 > OPEN_W) ?
                           OPENNESS_FRACTION_BITS + 1 : OPEN_W;
    localparam int XW    = CMP_W + 21;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [CMP_W-1:0] ONE_F = CMP_W'(1) << OPENNESS_FRACTION_BITS;

    logic [DIV_W-1:0]          q_reg;
    logic [DIV_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [POS_W-1:0]          pos_reg;
    logic                      enc_ok_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [LEVEL_W-1:0]        lev_c_reg;
    logic [POS_W-1:0]          ref_reg;
    logic [7:0]                raw_reg;
    logic [POS_W-1:0]          vel_reg;

    logic [STEP_W-1:0]         step_eff;
    logic [OPEN_W-1:0]         op_min;
    logic [CMP_W-1:0]          op_ext;
    logic [CMP_W-1:0]          op_cl;
    logic [CMP_W-1:0]          clo;
    logic [XW-1:0]             x_num;
    logic [XW-1:0]             y_full;

    logic [DIV_W:0]            rem_sh;
    logic                      q_bit;
    logic [DIV_W:0]            rem_new;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic signed [MUL_B_W-1:0] open26;
    logic signed [MUL_B_W-1:0] closed26;
    logic signed [MUL_B_W-1:0] ref26;
    logic signed [MUL_B_W-1:0] pos26;
    logic signed [8:0]         raw_diff;
    logic [LEVEL_W-1:0]        one_minus;

    logic signed [PROD_W-1:0]  ref_rnd;
    logic signed [PROD_W-1:0]  ref_sh;
    logic signed [MUL_B_W-1:0] ref_rs;
    logic signed [MUL_B_W-1:0] ref_sum;
    logic signed [PROD_W-1:0]  raw_t;
    logic signed [PROD_W-1:0]  raw_rnd;
    logic signed [PROD_W-1:0]  vel_rnd;
    logic signed [PROD_W-1:0]  vel_sh;
    logic signed [PROD_W-1:0]  lim;
    logic signed [PROD_W-1:0]  vel_sat;

    assign step_eff = (cfg.level_step == '0) ? STEP_W'(1) : cfg.level_step;
    assign op_min   = (left_openness < right_openness) ? left_openness : right_openness;
    assign op_ext   = CMP_W'(op_min);
    assign op_cl    = (op_ext > ONE_F) ? ONE_F : op_ext;
    assign clo      = ONE_F - op_cl;
    assign x_num    = (XW'(clo) << 17) + (XW'(step_eff) << OPENNESS_FRACTION_BITS);
    assign y_full   = x_num >> (OPENNESS_FRACTION_BITS + 1);

    assign rem_sh  = {rem_reg, q_reg[DIV_W-1]};
    assign q_bit   = rem_sh >= {1'b0, step_eff};
    assign rem_new = q_bit ? rem_sh - {1'b0, step_eff} : rem_sh;

    assign open26    = {{2{cfg.lid_open_limit[POS_W-1]}}, cfg.lid_open_limit};
    assign closed26  = {{2{cfg.lid_closed_limit[POS_W-1]}}, cfg.lid_closed_limit};
    assign ref26     = {{2{ref_reg[POS_W-1]}}, ref_reg};
    assign pos26     = {{2{pos_reg[POS_W-1]}}, pos_reg};
    assign raw_diff  = $signed({1'b0, cfg.raw_open_value}) -
                       $signed({1'b0, cfg.raw_closed_value});
    assign one_minus = ONE_Q16 - lev_c_reg;

    always_comb begin
        case (ctl.mul_sel)
            MUL_LEV: begin
                mul_a = $signed({1'b0, step_eff});
                mul_b = $signed({9'b0, q_reg[LEVEL_W-1:0]});
            end
            MUL_REF: begin
                mul_a = $signed({4'b0, lev_c_reg});
                mul_b = closed26 - open26;
            end
            MUL_RAW: begin
                mul_a = $signed({4'b0, one_minus});
                mul_b = {{17{raw_diff[8]}}, raw_diff};
            end
            MUL_VEL: begin
                mul_a = $signed({5'b0, cfg.velocity_gain});
                mul_b = ref26 - pos26;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    assign ref_rnd = prod_reg + (prod_reg[PROD_W-1] ? 47'sd32767 : 47'sd32768);
    assign ref_sh  = ref_rnd >>> 16;
    assign ref_rs  = $signed(ref_sh[MUL_B_W-1:0]);
    assign ref_sum = open26 + ref_rs;

    assign raw_t   = prod_reg + $signed({23'b0, cfg.raw_closed_value, 16'b0});
    assign raw_rnd = raw_t + 47'sd32768;

    assign vel_rnd = prod_reg + (prod_reg[PROD_W-1] ? 47'sd127 : 47'sd128);
    assign vel_sh  = vel_rnd >>> 8;
    assign lim     = $signed({24'b0, cfg.velocity_limit});

    always_comb begin
        if (vel_sh > lim) begin
            vel_sat = lim;
        end else if (vel_sh < -lim) begin
            vel_sat = -lim;
        end else begin
            vel_sat = vel_sh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctl.alu_op == ALU_LOAD && in_beat) begin
            cnt_reg <= CNT_W'(DIV_W);
        end else if (ctl.alu_op == ALU_DIV && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_sel != MUL_NONE) begin
            prod_reg <= prod_c;
        end
        unique case (ctl.alu_op)
            ALU_LOAD: begin
                if (in_beat) begin
                    q_reg      <= y_full[DIV_W-1:0];
                    rem_reg    <= '0;
                    pos_reg    <= measured_position;
                    enc_ok_reg <= encoder_ok;
                end
            end
            ALU_DIV: begin
                q_reg   <= {q_reg[DIV_W-2:0], q_bit};
                rem_reg <= rem_new[DIV_W-1:0];
            end
            ALU_CLAMP: begin
                lev_c_reg <= (prod_reg > 47'sd65536) ? ONE_Q16 : prod_reg[LEVEL_W-1:0];
            end
            ALU_REF: begin
                ref_reg <= ref_sum[POS_W-1:0];
            end
            ALU_RAW: begin
                raw_reg <= raw_t[PROD_W-1] ? 8'd0 : raw_rnd[23:16];
            end
            ALU_VEL: begin
                vel_reg <= vel_sat[POS_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign status.div_last   = (cnt_reg == CNT_W'(1));
    assign result.level      = q_reg[LEVEL_W-1:0];
    assign result.raw        = raw_reg;
    assign result.pos_ref    = ref_reg;
    assign result.vel        = vel_reg;
    assign result.encoder_ok = enc_ok_reg;

endmodule

// File: rtl/eyelid_level_retarget_controller.sv
// Eyelid level retarget controller.
// Input stream: one beat per sample carries both eye openness values and the
// lid encoder reading in s_tdata, and the encoder status in s_tuser.
// Output stream: exactly one beat per input beat. m_tuser carries the command
// kind (none, raw, position reference, velocity) and the step status; m_tdata
// carries the raw value, position reference, velocity command and level.
// Configuration: cfg_we writes cfg_data into register cfg_index at once; write
// only while no sample is in flight.
// Sequencing: a microcoded sequencer runs each sample through a
// 20-step restoring divider for the level, then four multiply and round step
// pairs on one shared multiplier and an emit step; s_tready is high only at
// the idle step, so a new sample is taken only after the emit step is done.
// A new input beat is accepted while the previous result still waits on
// m_tready; the sequencer holds at its last step until the output register
// frees up, so a stalled receiver throttles the input side.
// Reset clears the sequencer, the output valid flag, the stored level and loads
// the default register values; s_tready stays low while reset is held.
module eyelid_level_retarget_controller
    import elrc_pkg::*;
#(
    parameter int OPENNESS_FRACTION_BITS = OFB_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // left_openness[16:0], right_openness[33:17], measured_position[57:34]
    input  logic [63:0]           s_tdata,
    // encoder_ok[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // raw_command[7:0], position_reference[31:8], velocity_command[55:32],
    // closeness_level[72:56]
    output logic [79:0]           m_tdata,
    // command_kind[1:0], step_ok[2]
    output logic [2:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [1:0]         control_mode_reg;
    logic [STEP_W-1:0]  level_step_reg;
    logic [7:0]         raw_closed_value_reg;
    logic [7:0]         raw_open_value_reg;
    logic [POS_W-1:0]   lid_open_limit_reg;
    logic [POS_W-1:0]   lid_closed_limit_reg;
    logic [15:0]        velocity_gain_reg;
    logic [22:0]        velocity_limit_reg;
    cfg_t               cfg;

    logic [PC_W-1:0]    pc_reg;
    logic [PC_W-1:0]    pc_next;
    ctl_word_t          ctl;
    logic               cond_met;
    logic               s_beat;
    logic               out_free;
    logic               out_load;
    dp_status_t         dp_status;
    dp_result_t         dp_res;

    logic [LEVEL_W-1:0] last_level_reg;
    logic               level_known_reg;
    logic               changed;
    logic [1:0]         kind;
    logic               ok;

    logic               m_tvalid_reg;
    logic [1:0]         m_kind_reg;
    logic               m_ok_reg;
    logic [7:0]         m_raw_reg;
    logic [POS_W-1:0]   m_ref_reg;
    logic [POS_W-1:0]   m_vel_reg;
    logic [LEVEL_W-1:0] m_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            control_mode_reg     <= MODE_VELOCITY;
            level_step_reg       <= 20'd6554;
            raw_closed_value_reg <= 8'd35;
            raw_open_value_reg   <= 8'd60;
            lid_open_limit_reg   <= '0;
            lid_closed_limit_reg <= '0;
            velocity_gain_reg    <= 16'd2560;
            velocity_limit_reg   <= 23'd25600;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CONTROL_MODE:     control_mode_reg     <= cfg_data[1:0];
                REG_LEVEL_STEP:       level_step_reg       <= cfg_data[STEP_W-1:0];
                REG_RAW_CLOSED_VALUE: raw_closed_value_reg <= cfg_data[7:0];
                REG_RAW_OPEN_VALUE:   raw_open_value_reg   <= cfg_data[7:0];
                REG_LID_OPEN_LIMIT:   lid_open_limit_reg   <= cfg_data[POS_W-1:0];
                REG_LID_CLOSED_LIMIT: lid_closed_limit_reg <= cfg_data[POS_W-1:0];
                REG_VELOCITY_GAIN:    velocity_gain_reg    <= cfg_data[15:0];
                REG_VELOCITY_LIMIT:   velocity_limit_reg   <= cfg_data[22:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.control_mode     = control_mode_reg;
    assign cfg.level_step       = level_step_reg;
    assign cfg.raw_closed_value = raw_closed_value_reg;
    assign cfg.raw_open_value   = raw_open_value_reg;
    assign cfg.lid_open_limit   = lid_open_limit_reg;
    assign cfg.lid_closed_limit = lid_closed_limit_reg;
    assign cfg.velocity_gain    = velocity_gain_reg;
    assign cfg.velocity_limit   = velocity_limit_reg;

    assign ctl      = ucode_rom(pc_reg);
    assign s_tready = aresetn && (pc_reg == STEP_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (ctl.cond)
            COND_ALWAYS:   cond_met = 1'b1;
            COND_IN_BEAT:  cond_met = s_beat;
            COND_DIV_LAST: cond_met = dp_status.div_last;
            COND_OUT_FREE: cond_met = out_free;
            default:       cond_met = 1'b1;
        endcase
    end

    assign pc_next  = cond_met ? ctl.target : pc_reg;
    assign out_load = (ctl.alu_op == ALU_EMIT) && cond_met;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    elrc_datapath #(
        .OPENNESS_FRACTION_BITS(OPENNESS_FRACTION_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .in_beat           (s_beat),
        .left_openness     (s_tdata[16:0]),
        .right_openness    (s_tdata[33:17]),
        .measured_position (s_tdata[57:34]),
        .encoder_ok        (s_tuser[0]),
        .cfg               (cfg),
        .status            (dp_status),
        .result            (dp_res)
    );

    assign changed = !level_known_reg || (dp_res.level != last_level_reg);

    always_comb begin
        kind = KIND_NONE;
        ok   = 1'b1;
        case (control_mode_reg)
            MODE_RAW: begin
                if (changed) begin
                    kind = KIND_RAW;
                end
            end
            MODE_POSITION: begin
                if (changed) begin
                    kind = KIND_POSITION;
                end
            end
            default: begin
                if (dp_res.encoder_ok) begin
                    kind = KIND_VELOCITY;
                end else begin
                    ok = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg    <= 1'b0;
            last_level_reg  <= '0;
            level_known_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg    <= 1'b1;
            last_level_reg  <= dp_res.level;
            level_known_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg    <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg  <= kind;
            m_ok_reg    <= ok;
            m_raw_reg   <= (kind == KIND_RAW) ? dp_res.raw : 8'd0;
            m_ref_reg   <= (kind == KIND_POSITION || kind == KIND_VELOCITY) ?
                           dp_res.pos_ref : '0;
            m_vel_reg   <= (kind == KIND_VELOCITY) ? dp_res.vel : '0;
            m_level_reg <= dp_res.level;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_level_reg, m_vel_reg, m_ref_reg, m_raw_reg};
    assign m_tuser  = {m_ok_reg, m_kind_reg};

    a_level_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> level_known_reg && last_level_reg == $past(dp_res.level))
        else $error("stored level does not follow the emitted result");

    a_vel_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_kind_reg == KIND_VELOCITY |->
            $signed(m_vel_reg) <= $signed({1'b0, velocity_limit_reg}) &&
            $signed(m_vel_reg) >= -$signed({1'b0, velocity_limit_reg}))
        else $error("velocity command outside its limit");

    a_fail_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_ok_reg |-> m_kind_reg == KIND_NONE)
        else $error("command issued on a failed step");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= STEP_EMIT)
        else $error("sequencer left its program");

    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> pc_reg == STEP_DIV && !out_load)
        else $error("input beat did not start the divider");

endmodule
